### hdl/bgs_pkg.sv
`default_nettype none
package bgs_pkg;

  localparam int unsigned MV_W    = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned EMPTY_W = 12;
  localparam int unsigned STEP_W  = 7;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;

  localparam logic [MV_W-1:0]    FULL_RESET  = 16'd4200;
  localparam logic [EMPTY_W-1:0] EMPTY_RESET = 12'd3300;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 7'd15;

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // table points between the full and empty points
  localparam int unsigned NUM_MID = 10;
  localparam int unsigned PT_W    = 4;
  localparam logic [PT_W-1:0] PT_FIRST = 4'd1;
  localparam logic [PT_W-1:0] PT_LAST  = 4'd11;

  localparam logic [MV_W-1:0] MID_MV [NUM_MID] = '{
    16'd4110, 16'd4020, 16'd3950, 16'd3870, 16'd3840,
    16'd3800, 16'd3770, 16'd3730, 16'd3690, 16'd3610
  };
  localparam logic [PCT_W-1:0] MID_PCT [NUM_MID] = '{
    7'd92, 7'd84, 7'd75, 7'd62, 7'd53, 7'd42, 7'd32, 7'd20, 7'd10, 7'd5
  };

  // interpolation divider: (delta_pct * up + span/2) / span
  localparam int unsigned DIVIDEND_W = PCT_W + MV_W;
  localparam int unsigned DIVISOR_W  = MV_W;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [MV_W-1:0] point_mv(input logic [PT_W-1:0] idx,
                                              input logic [MV_W-1:0] full_mv,
                                              input logic [EMPTY_W-1:0] empty_mv);
    logic [PT_W-1:0] mid;
    mid = idx - PT_W'(1);
    if (idx == '0) begin
      point_mv = full_mv;
    end else if (idx >= PT_LAST) begin
      point_mv = MV_W'(empty_mv);
    end else begin
      point_mv = MID_MV[mid];
    end
  endfunction

  function automatic logic [PCT_W-1:0] point_pct(input logic [PT_W-1:0] idx);
    logic [PT_W-1:0] mid;
    mid = idx - PT_W'(1);
    if (idx == '0) begin
      point_pct = PCT_FULL;
    end else if (idx >= PT_LAST) begin
      point_pct = PCT_EMPTY;
    end else begin
      point_pct = MID_PCT[mid];
    end
  endfunction

endpackage
`default_nettype wire

### hdl/bgs_div.sv
`default_nettype none
module bgs_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bgs_pkg::div_req_t req_i,
  output bgs_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned NW  = bgs_pkg::DIVIDEND_W;
  localparam int unsigned DW  = bgs_pkg::DIVISOR_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dsr_q, dsr_d;

  logic [DW:0] trial;
  logic        fits;

  // one restoring step per cycle
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

### hdl/battery_gauge_smoother.sv
// battery gauge smoother
// in channel: one millivolt sample per request on sample_millivolts_i, taken
// when in_valid_i and in_ready_o are both high. in_ready_o is high only while
// the sequencer is idle, so one sample is worked on at a time.
// out channel: a request carries the rounded average and the new displayed
// percent, and is raised only when the displayed percent changes (always for
// the first sample after reset). it stays in an output register until
// out_ready_i; meanwhile the next sample is accepted and worked on.
// path from accept to out_valid_o: when the average lies at or beyond the full
// or empty point, the states avg, rnd, clamp and done; otherwise avg, rnd and
// clamp, a table scan over points 1 to 11, segment setup (seg, mul, divst), the
// 23-step serial divider and done (a misordered segment skips the divider and
// goes from seg to done). the sequencer returns to idle before the next sample
// is taken.
// if a new request is ready while the output register still holds an untaken
// request, the sequencer waits until the receiver takes it.
// config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 full mv, 1 empty mv, 2 rise step); write only while idle.
// reset: average zero, no percent shown, registers at 4200, 3300, 15.
`default_nettype none
module battery_gauge_smoother #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [bgs_pkg::MV_W-1:0]       sample_millivolts_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [bgs_pkg::MV_W-1:0]            smooth_millivolts_o,
  output logic [bgs_pkg::PCT_W-1:0]           shown_percent_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bgs_pkg::MV_W-1:0]       cfg_wdata_i
);

  localparam int unsigned MV_W  = bgs_pkg::MV_W;
  localparam int unsigned PCT_W = bgs_pkg::PCT_W;
  localparam int unsigned PT_W  = bgs_pkg::PT_W;
  localparam int unsigned NW    = bgs_pkg::DIVIDEND_W;
  localparam int unsigned AVG_W = MV_W + FRACTION_BITS;
  localparam logic [AVG_W:0] HALF_LSB = (AVG_W + 1)'(1) << (FRACTION_BITS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_AVG   = 4'd1;
  localparam logic [3:0] ST_RND   = 4'd2;
  localparam logic [3:0] ST_CLAMP = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_SEG   = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_DIVST = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // control state
  logic [3:0]                    state_q, state_d;
  logic [AVG_W-1:0]              avg_q, avg_d;
  logic [PCT_W-1:0]              disp_q, disp_d;
  logic                          disp_valid_q, disp_valid_d;
  logic                          out_valid_q, out_valid_d;
  logic [MV_W-1:0]               full_q, full_d;
  logic [bgs_pkg::EMPTY_W-1:0]   empty_q, empty_d;
  logic [bgs_pkg::STEP_W-1:0]    step_q, step_d;
  logic [PT_W-1:0]               idx_q, idx_d;

  // payload
  logic [MV_W-1:0]  sample_q, sample_d;
  logic [MV_W-1:0]  smooth_q, smooth_d;
  logic [MV_W-1:0]  hi_q, hi_d;
  logic [MV_W-1:0]  lo_q, lo_d;
  logic [PCT_W-1:0] plo_q, plo_d;
  logic [PCT_W-1:0] phi_q, phi_d;
  logic [MV_W-1:0]  span_q, span_d;
  logic [MV_W-1:0]  up_q, up_d;
  logic [NW-1:0]    numer_q, numer_d;
  logic [PCT_W-1:0] pct_q, pct_d;
  logic [MV_W-1:0]  out_mv_q, out_mv_d;
  logic [PCT_W-1:0] out_pct_q, out_pct_d;

  bgs_pkg::div_req_t div_req;
  bgs_pkg::div_rsp_t div_rsp;

  logic             in_fire;
  logic [AVG_W+1:0] avg_sum;
  logic [AVG_W:0]   avg_round;
  logic [MV_W-1:0]  scan_lo;
  logic [MV_W-1:0]  seg_span;
  logic [MV_W-1:0]  seg_up;
  logic [PCT_W-1:0] delta_pct;
  logic [PCT_W:0]   rise;
  logic             take;
  logic [PCT_W-1:0] next_pct;
  logic             emit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // three quarters of the old average plus a quarter of the sample, rounded
  assign avg_sum = (AVG_W + 2)'({avg_q, 1'b0}) + (AVG_W + 2)'(avg_q)
                 + (AVG_W + 2)'({sample_q, {FRACTION_BITS{1'b0}}}) + (AVG_W + 2)'(2);
  assign avg_round = (AVG_W + 1)'(avg_q) + HALF_LSB;

  assign scan_lo   = bgs_pkg::point_mv(idx_q, full_q, empty_q);
  assign seg_span  = hi_q - lo_q;
  assign seg_up    = smooth_q - lo_q;
  assign delta_pct = phi_q - plo_q;

  assign rise     = {1'b0, pct_q} - {1'b0, disp_q};
  assign take     = !disp_valid_q || (pct_q < disp_q)
                 || (!rise[PCT_W] && (rise[PCT_W-1:0] >= step_q));
  assign next_pct = take ? pct_q : disp_q;
  assign emit     = !disp_valid_q || (next_pct != disp_q);

  assign div_req.start    = (state_q == ST_DIVST);
  assign div_req.dividend = numer_q;
  assign div_req.divisor  = span_q;

  always_comb begin
    state_d      = state_q;
    avg_d        = avg_q;
    disp_d       = disp_q;
    disp_valid_d = disp_valid_q;
    out_valid_d  = out_valid_q;
    full_d       = full_q;
    empty_d      = empty_q;
    step_d       = step_q;
    idx_d        = idx_q;
    sample_d     = sample_q;
    smooth_d     = smooth_q;
    hi_d         = hi_q;
    lo_d         = lo_q;
    plo_d        = plo_q;
    phi_d        = phi_q;
    span_d       = span_q;
    up_d         = up_q;
    numer_d      = numer_q;
    pct_d        = pct_q;
    out_mv_d     = out_mv_q;
    out_pct_d    = out_pct_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgs_pkg::REG_FULL:  full_d  = cfg_wdata_i;
        bgs_pkg::REG_EMPTY: empty_d = cfg_wdata_i[bgs_pkg::EMPTY_W-1:0];
        bgs_pkg::REG_STEP:  step_d  = cfg_wdata_i[bgs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sample_d = sample_millivolts_i;
          state_d  = ST_AVG;
        end
      end
      ST_AVG: begin
        // a zero average is seeded by the sample
        if (avg_q == '0) begin
          avg_d = {sample_q, {FRACTION_BITS{1'b0}}};
        end else begin
          avg_d = avg_sum[AVG_W+1:2];
        end
        state_d = ST_RND;
      end
      ST_RND: begin
        smooth_d = avg_round[AVG_W] ? {MV_W{1'b1}} : avg_round[AVG_W-1:FRACTION_BITS];
        state_d  = ST_CLAMP;
      end
      ST_CLAMP: begin
        idx_d = bgs_pkg::PT_FIRST;
        if (smooth_q >= full_q) begin
          pct_d   = bgs_pkg::PCT_FULL;
          state_d = ST_DONE;
        end else if (smooth_q <= MV_W'(empty_q)) begin
          pct_d   = bgs_pkg::PCT_EMPTY;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // first point at or below the voltage; the empty point always hits
        if (smooth_q >= scan_lo || idx_q >= bgs_pkg::PT_LAST) begin
          lo_d    = scan_lo;
          hi_d    = bgs_pkg::point_mv(idx_q - PT_W'(1), full_q, empty_q);
          plo_d   = bgs_pkg::point_pct(idx_q);
          phi_d   = bgs_pkg::point_pct(idx_q - PT_W'(1));
          state_d = ST_SEG;
        end else begin
          idx_d = idx_q + PT_W'(1);
        end
      end
      ST_SEG: begin
        // a misordered segment gives the lower point's percent
        if (hi_q <= lo_q) begin
          pct_d   = plo_q;
          state_d = ST_DONE;
        end else begin
          span_d  = seg_span;
          up_d    = (seg_up > seg_span) ? seg_span : seg_up;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        numer_d = NW'(delta_pct * up_q) + NW'(span_q >> 1);
        state_d = ST_DIVST;
      end
      ST_DIVST: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pct_d   = plo_q + div_rsp.quotient[PCT_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!emit) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          disp_d       = next_pct;
          disp_valid_d = 1'b1;
          out_valid_d  = 1'b1;
          out_mv_d     = smooth_q;
          out_pct_d    = next_pct;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      avg_q        <= '0;
      disp_q       <= '0;
      disp_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      full_q       <= bgs_pkg::FULL_RESET;
      empty_q      <= bgs_pkg::EMPTY_RESET;
      step_q       <= bgs_pkg::STEP_RESET;
      idx_q        <= bgs_pkg::PT_FIRST;
    end else begin
      state_q      <= state_d;
      avg_q        <= avg_d;
      disp_q       <= disp_d;
      disp_valid_q <= disp_valid_d;
      out_valid_q  <= out_valid_d;
      full_q       <= full_d;
      empty_q      <= empty_d;
      step_q       <= step_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    smooth_q  <= smooth_d;
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    plo_q     <= plo_d;
    phi_q     <= phi_d;
    span_q    <= span_d;
    up_q      <= up_d;
    numer_q   <= numer_d;
    pct_q     <= pct_d;
    out_mv_q  <= out_mv_d;
    out_pct_q <= out_pct_d;
  end

  bgs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o         = out_valid_q;
  assign smooth_millivolts_o = out_mv_q;
  assign shown_percent_o     = out_pct_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("sequencer took a sample but stayed ready");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shown_percent_o <= bgs_pkg::PCT_FULL)
    else $error("displayed percent above full");

  a_out_matches_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_pct_q == disp_q) && disp_valid_q)
    else $error("pending request out of step with displayed percent");

  a_disp_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disp_valid_q |=> disp_valid_q)
    else $error("displayed percent lost");

endmodule
`default_nettype wire
